// ===== hdl/mdio_management_master_defines.svh =====
// ---------------------------------------------------------------------------
// MDIO management master assertion macros
// Shared concurrent assertion forms for the MDIO master checkers.
// ---------------------------------------------------------------------------
`ifndef MDIO_MANAGEMENT_MASTER_DEFINES_SVH
`define MDIO_MANAGEMENT_MASTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define MDM_ASSERT_SAME(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("mdio master check failed");

// Next-cycle implication, disabled while reset is high
`define MDM_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("mdio master check failed");

`endif

// ===== hdl/mdm_pkg.sv =====
// ---------------------------------------------------------------------------
// MDIO management master package
// Shared constants, word layouts and types of the MDIO master.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mdm_pkg;

   // preamble length, 1 to 63 ones
   localparam int PREAMBLE_BITS = 32;
   localparam int CNT_W         = 6;

   // command codes
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_PRE   = 2'd3;

   // stream widths
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 24;

   // request tdata layout
   localparam int REQ_PHY_LSB   = 0;
   localparam int REQ_REG_LSB   = 5;
   localparam int REQ_WDATA_LSB = 10;
   localparam int REQ_MDIO_IN   = 26;

   // response tdata layout
   localparam int RSP_MDIO_OUT   = 0;
   localparam int RSP_MDIO_DRIVE = 1;
   localparam int RSP_MDC_ACTIVE = 2;
   localparam int RSP_BUSY       = 3;
   localparam int RSP_READ_VALID = 4;
   localparam int RSP_RDATA_LSB  = 5;
   localparam int RSP_USED_W     = 21;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // decoded command passed from front to back
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] frame;
      logic        mdio_in;
   } cmd_type;

   // one MDC period of results
   typedef struct packed {
      logic        mdio_out;
      logic        mdio_drive;
      logic        mdc_active;
      logic        busy_res;
      logic        read_valid;
      logic [15:0] read_data;
   } rsp_type;

endpackage

// ===== hdl/mdm_front.sv =====
// ---------------------------------------------------------------------------
// MDIO master front end
// Accepts request words, builds the 32-bit frame and registers the command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mdm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [mdm_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                              cmd_valid,
   input  logic                              cmd_ready,
   output mdm_pkg::cmd_type                  cmd
);
   import mdm_pkg::*;

   logic        valid_ff, valid_in;
   cmd_type     cmd_ff, cmd_in;
   logic [4:0]  phy;
   logic [4:0]  regad;
   logic [15:0] wdata;
   logic        take;

   assign req_tready = !valid_ff || cmd_ready;
   assign take       = req_tvalid && req_tready;

   assign phy   = req_tdata[REQ_PHY_LSB +: 5];
   assign regad = req_tdata[REQ_REG_LSB +: 5];
   assign wdata = req_tdata[REQ_WDATA_LSB +: 16];

   // frame: start 01, opcode, phy, reg, then turnaround and data for writes
   always_comb begin
      cmd_in         = cmd_ff;
      valid_in       = valid_ff;
      if (cmd_ready) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in       = 1'b1;
         cmd_in.op      = req_tuser;
         cmd_in.mdio_in = req_tdata[REQ_MDIO_IN];
         if (req_tuser == OP_READ) begin
            cmd_in.frame = {2'b01, 2'b10, phy, regad, 18'd0};
         end else begin
            cmd_in.frame = {2'b01, 2'b01, phy, regad, 2'b10, wdata};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

// ===== hdl/mdm_queue.sv =====
// ---------------------------------------------------------------------------
// MDIO master command queue
// Short FIFO of decoded commands between the front end and the sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  mdm_pkg::cmd_type  in_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output mdm_pkg::cmd_type  out_cmd
);
   import mdm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(QUEUE_DEPTH);

   cmd_type             store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]   count_ff, count_in;
   logic                push;
   logic                pop;

   assign in_ready  = count_ff != CNT_FULL;
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_cmd   = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ===== hdl/mdm_back.sv =====
// ---------------------------------------------------------------------------
// MDIO master sequencer
// Bit-serial Clause 22 sequencer, one MDC period per command word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  mdm_pkg::cmd_type                  cmd,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mdm_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import mdm_pkg::*;

   // sequence phases
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_PRE   = 3'd1;
   localparam logic [2:0] PH_LEAD  = 3'd2;
   localparam logic [2:0] PH_FRAME = 3'd3;
   localparam logic [2:0] PH_TAIL  = 3'd4;

   localparam logic [CNT_W-1:0] PRE_LAST     = CNT_W'(PREAMBLE_BITS);
   localparam logic [CNT_W-1:0] READ_DRIVEN  = CNT_W'(14);
   localparam logic [CNT_W-1:0] READ_SAMPLE  = CNT_W'(16);
   localparam logic [CNT_W-1:0] FRAME_LAST   = CNT_W'(32);

   logic [2:0]        phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [31:0]       tx_ff, tx_in;
   logic [15:0]       rx_ff, rx_in;
   logic              is_read_ff, is_read_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [2:0]        phase_eff;
   logic              take;

   assign cmd_ready = !rsp_valid_ff || rsp_tready;
   assign take      = cmd_valid && cmd_ready;

   // one MDC period: optional command start, then the phase action
   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      tx_in      = tx_ff;
      rx_in      = rx_ff;
      is_read_in = is_read_ff;
      rsp_in     = '0;
      phase_eff  = phase_ff;

      if (phase_ff > PH_TAIL) begin
         phase_eff = PH_IDLE;
      end

      // command start, taken only when idle
      if (phase_eff == PH_IDLE && cmd.op != OP_NONE) begin
         cnt_in = '0;
         if (cmd.op == OP_PRE) begin
            phase_eff  = PH_PRE;
            is_read_in = 1'b0;
         end else begin
            phase_eff  = PH_LEAD;
            is_read_in = cmd.op == OP_READ;
            tx_in      = cmd.frame;
         end
      end

      phase_in = phase_eff;
      case (phase_eff)
         PH_PRE: begin
            rsp_in.mdc_active = 1'b1;
            rsp_in.mdio_drive = 1'b1;
            rsp_in.mdio_out   = 1'b1;
            cnt_in            = cnt_in + 1'b1;
            if (cnt_in >= PRE_LAST) begin
               phase_in = PH_TAIL;
            end
         end
         PH_LEAD: begin
            rsp_in.mdc_active = 1'b1;
            cnt_in            = '0;
            phase_in          = PH_FRAME;
         end
         PH_FRAME: begin
            rsp_in.mdc_active = 1'b1;
            if (is_read_in && cnt_in >= READ_DRIVEN) begin
               if (cnt_in >= READ_SAMPLE) begin
                  rx_in = {rx_ff[14:0], cmd.mdio_in};
               end
            end else begin
               rsp_in.mdio_drive = 1'b1;
               rsp_in.mdio_out   = tx_in[31];
            end
            tx_in  = {tx_in[30:0], 1'b0};
            cnt_in = cnt_in + 1'b1;
            if (cnt_in >= FRAME_LAST) begin
               phase_in = PH_TAIL;
            end
         end
         PH_TAIL: begin
            rsp_in.mdc_active = 1'b1;
            rsp_in.read_valid = is_read_in;
            phase_in          = PH_IDLE;
            cnt_in            = '0;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      rsp_in.busy_res  = phase_in != PH_IDLE;
      rsp_in.read_data = rx_in;

      // response holds while stalled
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (take) begin
         rsp_valid_in = 1'b1;
      end
   end

   // sequencer state advances only on a taken word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         tx_ff        <= '0;
         rx_ff        <= '0;
         is_read_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff   <= phase_in;
            cnt_ff     <= cnt_in;
            tx_ff      <= tx_in;
            rx_ff      <= rx_in;
            is_read_ff <= is_read_in;
         end
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_USED_W)'(0), rsp_ff.read_data, rsp_ff.read_valid,
                        rsp_ff.busy_res, rsp_ff.mdc_active, rsp_ff.mdio_drive,
                        rsp_ff.mdio_out};

endmodule

// ===== hdl/mdio_management_master.sv =====
// A request word passes the front register, queue and output word register.
// Throughput: one word per cycle unless stalled, each one MDC period of the
// bit-serial sequencer; the front register and two-entry queue absorb stalls.
// Reset (synchronous, active high) empties the pipeline and queue and puts
// the sequencer in idle with counter, shift registers and read data at zero.
// ---------------------------------------------------------------------------
// MDIO management master
// Clause 22 MDIO master: preamble, read and write frames, one bit per word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdio_management_master (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [4:0] phy_num, [9:5] reg_num, [25:10] write_data, [26] mdio_in
   input  logic [mdm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [1:0] operation
   input  logic [mdm_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] mdio_out, [1] mdio_drive, [2] mdc_active, [3] busy_res,
   // [4] read_valid, [20:5] read_data
   output logic [mdm_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import mdm_pkg::*;

   logic    f_valid;
   logic    f_ready;
   cmd_type f_cmd;
   logic    q_valid;
   logic    q_ready;
   cmd_type q_cmd;

   mdm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd        (f_cmd)
   );

   mdm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   mdm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd_ready  (q_ready),
      .cmd        (q_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hdl/mdm_checker.sv =====
// ---------------------------------------------------------------------------
// MDIO master port checker
// Assertions on the response stream of the MDIO master, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mdio_management_master_defines.svh"

module mdm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [mdm_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import mdm_pkg::*;

   // stalled response word holds
   `MDM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // no level on MDIO unless the master drives it
   `MDM_ASSERT_SAME(a_out_driven, clock, reset, rsp_tvalid && !rsp_tdata[RSP_MDIO_DRIVE], !rsp_tdata[RSP_MDIO_OUT])

   // read completes on a clocked, released period
   `MDM_ASSERT_SAME(a_read_done, clock, reset, rsp_tvalid && rsp_tdata[RSP_READ_VALID], rsp_tdata[RSP_MDC_ACTIVE] && !rsp_tdata[RSP_MDIO_DRIVE] && !rsp_tdata[RSP_BUSY])

   // a sequence in progress always clocks MDC in that period
   `MDM_ASSERT_SAME(a_busy_clocks, clock, reset, rsp_tvalid && rsp_tdata[RSP_BUSY], rsp_tdata[RSP_MDC_ACTIVE])

endmodule

bind mdio_management_master mdm_checker u_mdm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_mdio_management_master.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MDIO management master testbench
// Feeds MDC-period words for preamble, read and write sequences, random
// command noise while busy, and a random MDIO input level. Every response
// word is checked field by field against an in-bench sequencer model. Both
// stream sides idle at random, and the response side holds off once long
// enough to back the block up.
// ---------------------------------------------------------------------------

module tb_mdio_management_master;

   import mdm_pkg::*;

   localparam int RANDOM_WORDS  = 1475;
   localparam int MAX_WAIT      = 17;
   localparam int LONG_HOLD     = 120;
   localparam int HOLD_AT_WORD  = 600;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int DRAIN_CYCLES  = 12;
   // frame timing in MDC periods
   localparam int READ_DRIVEN   = 14;
   localparam int READ_SAMPLE   = 16;
   localparam int FRAME_BITS    = 32;
   localparam int FRAME_PERIODS = FRAME_BITS + 2;

   typedef enum logic [2:0] {
      SEQ_IDLE, SEQ_PREAMBLE, SEQ_LEAD, SEQ_FRAME, SEQ_TAIL
   } seq_phase_type;

   typedef enum int { LINE_RANDOM, LINE_HIGH, LINE_LOW } line_mode_type;

   // one MDC period of request fields
   typedef struct packed {
      logic [1:0]  operation;
      logic [4:0]  phy_num;
      logic [4:0]  reg_num;
      logic [15:0] write_data;
      logic        mdio_in;
   } mdio_cmd_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   mdio_cmd_type pending_cmds[$];
   rsp_type      expected_periods[$];
   int           error_count = 0;
   int           cycle_count = 0;

   // sequencer model state
   seq_phase_type seq_phase = SEQ_IDLE;
   logic [5:0]    bit_cnt = '0;
   logic [31:0]   tx_frame = '0;
   logic [15:0]   rx_data = '0;
   logic          reading = 1'b0;

   mdio_management_master uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // advance the sequencer by one MDC period, return the expected word
   function automatic rsp_type next_mdio_period(input mdio_cmd_type cmd);
      rsp_type r;
      r = '0;
      if (seq_phase == SEQ_IDLE && cmd.operation != OP_NONE) begin
         bit_cnt = '0;
         if (cmd.operation == OP_PRE) begin
            seq_phase = SEQ_PREAMBLE;
            reading   = 1'b0;
         end else begin
            seq_phase = SEQ_LEAD;
            reading   = (cmd.operation == OP_READ);
            if (reading)
               tx_frame = {2'b01, 2'b10, cmd.phy_num, cmd.reg_num, 18'd0};
            else
               tx_frame = {2'b01, 2'b01, cmd.phy_num, cmd.reg_num, 2'b10,
                           cmd.write_data};
         end
      end
      case (seq_phase)
         SEQ_PREAMBLE: begin
            r.mdc_active = 1'b1;
            r.mdio_drive = 1'b1;
            r.mdio_out   = 1'b1;
            bit_cnt      = bit_cnt + 6'd1;
            if (bit_cnt >= PREAMBLE_BITS)
               seq_phase = SEQ_TAIL;
         end
         SEQ_LEAD: begin
            r.mdc_active = 1'b1;
            bit_cnt      = '0;
            seq_phase    = SEQ_FRAME;
         end
         SEQ_FRAME: begin
            r.mdc_active = 1'b1;
            if (reading && bit_cnt >= READ_DRIVEN) begin
               // turnaround, then sample MSB first
               if (bit_cnt >= READ_SAMPLE)
                  rx_data = {rx_data[14:0], cmd.mdio_in};
            end else begin
               r.mdio_drive = 1'b1;
               r.mdio_out   = tx_frame[31];
            end
            tx_frame = tx_frame << 1;
            bit_cnt  = bit_cnt + 6'd1;
            if (bit_cnt >= FRAME_BITS)
               seq_phase = SEQ_TAIL;
         end
         SEQ_TAIL: begin
            r.mdc_active = 1'b1;
            r.read_valid = reading;
            seq_phase    = SEQ_IDLE;
            bit_cnt      = '0;
         end
         default: ;
      endcase
      r.busy_res  = (seq_phase != SEQ_IDLE);
      r.read_data = rx_data;
      return r;
   endfunction

   // idle periods with no command
   task automatic queue_idle(input int count);
      mdio_cmd_type c;
      for (int i = 0; i < count; i++) begin
         c = mdio_cmd_type'($urandom);
         c.operation = OP_NONE;
         pending_cmds.push_back(c);
      end
   endtask

   // one full sequence; later periods carry random commands that must be ignored
   task automatic queue_sequence(input logic [1:0] op, input logic [4:0] phy,
                                 input logic [4:0] regad, input logic [15:0] wdata,
                                 input line_mode_type line);
      mdio_cmd_type c;
      int           periods;
      periods = (op == OP_PRE) ? PREAMBLE_BITS + 1 : FRAME_PERIODS;
      for (int i = 0; i < periods; i++) begin
         if (i == 0) begin
            c.operation  = op;
            c.phy_num    = phy;
            c.reg_num    = regad;
            c.write_data = wdata;
         end else begin
            c = mdio_cmd_type'($urandom);
         end
         if (line == LINE_RANDOM)
            c.mdio_in = 1'($urandom_range(0, 1));
         else
            c.mdio_in = (line == LINE_HIGH);
         pending_cmds.push_back(c);
      end
   endtask

   task automatic report_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // request driver
   mdio_cmd_type offered;
   int           gap_left = 0;
   int           send_quiet = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            expected_periods.push_back(next_mdio_period(offered));
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            offered = pending_cmds.pop_front();
            req_tdata <= REQ_TDATA_W'({offered.mdio_in, offered.write_data,
                                       offered.reg_num, offered.phy_num});
            req_tuser  <= offered.operation;
            req_tvalid <= 1'b1;
            if (send_quiet > 0) begin
               send_quiet--;
               gap_left = 0;
            end else begin
               gap_left = $urandom_range(0, MAX_WAIT);
               if ($urandom_range(0, 39) == 0)
                  send_quiet = $urandom_range(20, 80);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor and checker
   rsp_type want;
   int      stall_left = 0;
   int      recv_quiet = 0;
   int      words_seen = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_periods.size() == 0) begin
               $display("%0t: unexpected word, expected none, got %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = expected_periods.pop_front();
               report_field("mdio_out", want.mdio_out, rsp_tdata[RSP_MDIO_OUT]);
               report_field("mdio_drive", want.mdio_drive, rsp_tdata[RSP_MDIO_DRIVE]);
               report_field("mdc_active", want.mdc_active, rsp_tdata[RSP_MDC_ACTIVE]);
               report_field("busy_res", want.busy_res, rsp_tdata[RSP_BUSY]);
               report_field("read_valid", want.read_valid, rsp_tdata[RSP_READ_VALID]);
               report_field("read_data", want.read_data,
                            rsp_tdata[RSP_RDATA_LSB +: 16]);
            end
            words_seen++;
            if (words_seen == HOLD_AT_WORD) begin
               // long hold-off so the request side backs up
               stall_left = LONG_HOLD;
            end else if (recv_quiet > 0) begin
               recv_quiet--;
               stall_left = 0;
            end else begin
               stall_left = $urandom_range(0, MAX_WAIT);
               if ($urandom_range(0, 39) == 0)
                  recv_quiet = $urandom_range(20, 80);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      mdio_cmd_type c;
      int           target;
      int           pick;

      // directed: idle with every field high, then each sequence at its extremes
      c = '1;
      c.operation = OP_NONE;
      pending_cmds.push_back(c);
      queue_sequence(OP_PRE, 5'd0, 5'd0, 16'h0000, LINE_RANDOM);
      queue_sequence(OP_READ, 5'd31, 5'd0, 16'h0000, LINE_HIGH);
      queue_idle(1);
      queue_sequence(OP_READ, 5'd0, 5'd31, 16'hFFFF, LINE_LOW);
      queue_sequence(OP_WRITE, 5'd31, 5'd31, 16'hFFFF, LINE_RANDOM);
      queue_sequence(OP_WRITE, 5'd0, 5'd0, 16'h0000, LINE_HIGH);
      queue_sequence(OP_READ, 5'h15, 5'h0A, 16'h5555, LINE_RANDOM);
      queue_sequence(OP_PRE, 5'd31, 5'd31, 16'hFFFF, LINE_LOW);
      queue_sequence(OP_WRITE, 5'h0A, 5'h15, 16'hA5C3, LINE_RANDOM);
      queue_idle(2);

      // random: mostly whole sequences, some stray commands and idle gaps
      target = pending_cmds.size() + RANDOM_WORDS;
      while (pending_cmds.size() < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            queue_sequence(2'($urandom_range(1, 3)), 5'($urandom), 5'($urandom),
                           16'($urandom), LINE_RANDOM);
            queue_idle($urandom_range(0, 2));
         end else begin
            c = mdio_cmd_type'($urandom);
            pending_cmds.push_back(c);
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_tvalid || expected_periods.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
